// ===== sv/gfad_pkg.sv =====
package gfad_pkg;

  localparam int unsigned AddrW = 19;
  localparam int unsigned LenW  = 6;
  localparam int unsigned ColW  = 10;
  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] EscCode   = 8'h1B;
  localparam logic [ByteW-1:0] LeadMin   = 8'hA1;
  localparam logic [ByteW-1:0] LeadMid   = 8'hB0;
  localparam logic [ByteW-1:0] LeadHigh  = 8'hCA;
  localparam logic [ByteW-1:0] AsciiBase = 8'h20;

  localparam logic [AddrW-1:0] RowStride = 19'd3008;
  localparam logic [AddrW-1:0] BaseLow   = 19'd3008;
  localparam logic [AddrW-1:0] BaseMid   = 19'd39104;
  localparam logic [AddrW-1:0] BaseHigh  = 19'd114304;

  localparam logic [LenW-1:0] LenSingle = 6'd16;
  localparam logic [LenW-1:0] LenDouble = 6'd32;

  localparam logic [ColW-1:0] ColMax     = 10'd1023;
  localparam logic [ColW:0]   StepNarrow = 11'd8;
  localparam logic [ColW:0]   StepWide   = 11'd16;

  typedef struct packed {
    logic             escape_pending;
    logic             lead_pending;
    logic [ByteW-1:0] lead_byte;
    logic [ByteW-1:0] current_color;
    logic [ColW-1:0]  column_position;
  } state_t;

  typedef struct packed {
    logic [AddrW-1:0] flash_address;
    logic [LenW-1:0]  read_length;
    logic [ColW-1:0]  glyph_column;
    logic [ByteW-1:0] glyph_color;
    logic             error_status;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] text_byte;
    logic             line_start;
  } request_t;

endpackage

// ===== sv/gfad_in_stage.sv =====
module gfad_in_stage
  import gfad_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             line_start_i,
  output logic             in_stall_o,
  input  logic             consume_i,
  output request_t         req_o
);

  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  logic             ls_q;

  assign in_stall_o = valid_q & ~consume_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= text_byte_i;
      ls_q   <= line_start_i;
    end
  end

  assign req_o = '{valid: valid_q, text_byte: byte_q, line_start: ls_q};

endmodule

// ===== sv/gfad_decode.sv =====
module gfad_decode
  import gfad_pkg::*;
(
  input  state_t           state_i,
  input  logic             wide_i,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             line_start_i,
  output state_t           state_o,
  output logic             emit_o,
  output result_t          result_o
);

  state_t           s;
  logic [ByteW-1:0] lead_off;
  logic [AddrW-1:0] base;
  logic [AddrW-1:0] row_addr;
  logic [AddrW-1:0] trail_addr;
  logic [ColW:0]    step;
  logic [ColW:0]    col_sum;
  logic             advance;

  always_comb begin
    s = state_i;
    if (line_start_i) begin
      s.column_position = '0;
      s.escape_pending  = 1'b0;
      s.lead_pending    = 1'b0;
    end

    if (s.lead_byte < LeadMid) begin
      lead_off = s.lead_byte - LeadMin;
      base     = BaseLow;
    end else if (s.lead_byte < LeadHigh) begin
      lead_off = s.lead_byte - LeadMid;
      base     = BaseMid;
    end else begin
      lead_off = s.lead_byte - LeadHigh;
      base     = BaseHigh;
    end
    row_addr   = AddrW'(lead_off) * RowStride + base;
    trail_addr = AddrW'(text_byte_i - LeadMin) << 5;

    state_o  = s;
    emit_o   = 1'b0;
    advance  = 1'b0;
    step     = StepWide;
    result_o = '{flash_address: '0, read_length: LenDouble,
                 glyph_column: s.column_position, glyph_color: s.current_color,
                 error_status: 1'b0};

    if (s.escape_pending) begin
      state_o.current_color  = text_byte_i;
      state_o.escape_pending = 1'b0;
    end else if (s.lead_pending) begin
      state_o.lead_pending = 1'b0;
      emit_o               = 1'b1;
      if (text_byte_i < LeadMin) begin
        result_o.error_status = 1'b1;
      end else begin
        result_o.flash_address = row_addr + trail_addr;
        advance                = 1'b1;
      end
    end else if (text_byte_i == EscCode) begin
      state_o.escape_pending = 1'b1;
    end else if (text_byte_i < AsciiBase) begin
      emit_o = 1'b0;
    end else if (text_byte_i < LeadMin) begin
      emit_o                 = 1'b1;
      advance                = 1'b1;
      step                   = wide_i ? StepWide : StepNarrow;
      result_o.read_length   = LenSingle;
      result_o.flash_address = AddrW'(text_byte_i - AsciiBase) << 4;
    end else begin
      state_o.lead_byte    = text_byte_i;
      state_o.lead_pending = 1'b1;
    end

    col_sum = {1'b0, s.column_position} + step;
    if (advance) begin
      state_o.column_position = col_sum[ColW] ? ColMax : col_sum[ColW-1:0];
    end
  end

endmodule

// ===== sv/glyph_font_address_decoder.sv =====
// a request is registered in the input stage, and its result then in the result register
// throughput: one text byte per cycle while the result port is not stalled, set by the single decode stage
// bytes that give no glyph (escape, colour, lead, control) produce no result
// reset clears the state, the wide mode bit and both valid flags
module glyph_font_address_decoder
  import gfad_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wide_ascii_we_i,
  input  logic             wide_ascii_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             line_start_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [AddrW-1:0] flash_address_o,
  output logic [LenW-1:0]  read_length_o,
  output logic [ColW-1:0]  glyph_column_o,
  output logic [ByteW-1:0] glyph_color_o,
  output logic             error_status_o
);

  request_t req;
  state_t   state_q, state_d;
  result_t  result_q, result_d;
  logic     out_valid_q;
  logic     wide_q;
  logic     emit;
  logic     go;

  assign go = req.valid & (~out_valid_q | ~out_stall_i);

  gfad_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .text_byte_i (text_byte_i),
    .line_start_i(line_start_i),
    .in_stall_o  (in_stall_o),
    .consume_i   (go),
    .req_o       (req)
  );

  gfad_decode u_decode (
    .state_i     (state_q),
    .wide_i      (wide_q),
    .text_byte_i (req.text_byte),
    .line_start_i(req.line_start),
    .state_o     (state_d),
    .emit_o      (emit),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b0;
    end else if (wide_ascii_we_i) begin
      wide_q <= wide_ascii_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go) begin
        state_q <= state_d;
      end
      if (go) begin
        out_valid_q <= emit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign flash_address_o = result_q.flash_address;
  assign read_length_o   = result_q.read_length;
  assign glyph_column_o  = result_q.glyph_column;
  assign glyph_color_o   = result_q.glyph_color;
  assign error_status_o  = result_q.error_status;

  a_no_dual_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.escape_pending && state_q.lead_pending))
    else $error("escape and lead pending together");

  a_error_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.error_status |->
      result_q.flash_address == '0 && result_q.read_length == LenDouble)
    else $error("bad trail result malformed");

  a_len_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> result_q.read_length == LenSingle ||
                    result_q.read_length == LenDouble)
    else $error("illegal read length");

  a_col_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && !req.line_start |=> state_q.column_position >= $past(state_q.column_position))
    else $error("column moved backwards");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> req.valid && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

// ===== test/glyph_font_address_decoder_tb.sv =====
module glyph_font_address_decoder_tb;
  import gfad_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class glyph_tracker;
    bit               wide;
    bit               escape_seen;
    bit               lead_seen;
    logic [ByteW-1:0] lead_code;
    logic [ByteW-1:0] colour;
    logic [ColW-1:0]  column;
    result_t          expected_glyphs[$];
    int unsigned      failures;

    function new();
      wide        = 1'b0;
      escape_seen = 1'b0;
      lead_seen   = 1'b0;
      lead_code   = '0;
      colour      = '0;
      column      = '0;
      failures    = 0;
    endfunction

    function void advance(int unsigned by);
      int unsigned next;
      next = int'(column) + by;
      column = (next > int'(ColMax)) ? ColMax : ColW'(next);
    endfunction

    function void note_request(logic [ByteW-1:0] b, logic ls);
      result_t     glyph;
      int unsigned base;
      if (ls) begin
        column      = '0;
        escape_seen = 1'b0;
        lead_seen   = 1'b0;
      end
      glyph.glyph_column = column;
      glyph.glyph_color  = colour;
      if (escape_seen) begin
        colour      = b;
        escape_seen = 1'b0;
      end else if (lead_seen) begin
        lead_seen         = 1'b0;
        glyph.read_length = LenDouble;
        if (b < LeadMin) begin
          glyph.flash_address = '0;
          glyph.error_status  = 1'b1;
        end else begin
          if (lead_code < LeadMid) begin
            base = (int'(lead_code) - int'(LeadMin)) * int'(RowStride) + int'(BaseLow);
          end else if (lead_code < LeadHigh) begin
            base = (int'(lead_code) - int'(LeadMid)) * int'(RowStride) + int'(BaseMid);
          end else begin
            base = (int'(lead_code) - int'(LeadHigh)) * int'(RowStride) + int'(BaseHigh);
          end
          base = base + (int'(b) - int'(LeadMin)) * 32;
          glyph.flash_address = AddrW'(base);
          glyph.error_status  = 1'b0;
          advance(int'(StepWide));
        end
        expected_glyphs.push_back(glyph);
      end else if (b == EscCode) begin
        escape_seen = 1'b1;
      end else if (b < AsciiBase) begin
        // control bytes and zero give nothing
      end else if (b < LeadMin) begin
        glyph.flash_address = AddrW'((int'(b) - int'(AsciiBase)) * 16);
        glyph.read_length   = LenSingle;
        glyph.error_status  = 1'b0;
        expected_glyphs.push_back(glyph);
        advance(wide ? int'(StepWide) : int'(StepNarrow));
      end else begin
        lead_code = b;
        lead_seen = 1'b1;
      end
    endfunction

    function void check_glyph(result_t seen);
      result_t want;
      if (expected_glyphs.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected glyph: addr %h len %0d col %0d colour %h err %b",
                   seen.flash_address, seen.read_length, seen.glyph_column,
                   seen.glyph_color, seen.error_status);
        end
      end else begin
        want = expected_glyphs.pop_front();
        if (seen.flash_address !== want.flash_address ||
            seen.read_length !== want.read_length ||
            seen.glyph_column !== want.glyph_column ||
            seen.glyph_color !== want.glyph_color ||
            seen.error_status !== want.error_status) begin
          failures++;
          if (failures <= 10) begin
            $display("glyph mismatch: expected addr %h len %0d col %0d colour %h err %b",
                     want.flash_address, want.read_length, want.glyph_column,
                     want.glyph_color, want.error_status);
            $display("                got      addr %h len %0d col %0d colour %h err %b",
                     seen.flash_address, seen.read_length, seen.glyph_column,
                     seen.glyph_color, seen.error_status);
          end
        end
      end
    endfunction
  endclass

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             wide_ascii_we_i = 1'b0;
  logic             wide_ascii_i    = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] text_byte_i     = '0;
  logic             line_start_i    = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i     = 1'b0;
  logic [AddrW-1:0] flash_address_o;
  logic [LenW-1:0]  read_length_o;
  logic [ColW-1:0]  glyph_column_o;
  logic [ByteW-1:0] glyph_color_o;
  logic             error_status_o;

  glyph_tracker tracker = new();
  int unsigned  idle_max = 15;

  glyph_font_address_decoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wide_ascii_we_i (wide_ascii_we_i),
    .wide_ascii_i    (wide_ascii_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .line_start_i    (line_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .flash_address_o (flash_address_o),
    .read_length_o   (read_length_o),
    .glyph_column_o  (glyph_column_o),
    .glyph_color_o   (glyph_color_o),
    .error_status_o  (error_status_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    if (idle_max == 0) begin
      return 0;
    end
    return $urandom_range(0, idle_max);
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic ls);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    text_byte_i  <= b;
    line_start_i <= ls;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.note_request(b, ls);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.expected_glyphs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_wide(input logic v);
    @(posedge clk_i);
    wide_ascii_we_i <= 1'b1;
    wide_ascii_i    <= v;
    @(posedge clk_i);
    wide_ascii_we_i <= 1'b0;
    tracker.wide = v;
  endtask

  task automatic run_phase(input logic wide, input int unsigned idle,
                           input int unsigned ls_rate, input int unsigned count);
    int unsigned      sent;
    int unsigned      kind;
    logic             ls;
    logic [ByteW-1:0] lead;
    set_wide(wide);
    idle_max = idle;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      ls   = (ls_rate != 0) && ($urandom_range(1, ls_rate) == 1);
      lead = ByteW'($urandom_range(int'(LeadMin), 255));
      if (kind < 40) begin
        send_byte(ByteW'($urandom_range(int'(AsciiBase), int'(LeadMin) - 1)), ls);
        sent += 1;
      end else if (kind < 70) begin
        send_byte(lead, ls);
        send_byte(ByteW'($urandom_range(int'(LeadMin), 255)), $urandom_range(0, 29) == 0);
        sent += 2;
      end else if (kind < 78) begin
        send_byte(EscCode, ls);
        send_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
        sent += 2;
      end else if (kind < 86) begin
        send_byte(lead, ls);
        send_byte(ByteW'($urandom_range(0, int'(LeadMin) - 1)), 1'b0);
        sent += 2;
      end else if (kind < 92) begin
        send_byte(ByteW'($urandom_range(0, int'(AsciiBase) - 1)), ls);
        sent += 1;
      end else begin
        send_byte(ByteW'($urandom_range(0, 255)), ls);
        sent += 1;
      end
    end
    settle();
  endtask

  // result side: random hold-off before each result
  initial begin
    int unsigned hold;
    forever begin
      hold = draw_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      seen.flash_address = flash_address_o;
      seen.read_length   = read_length_o;
      seen.glyph_column  = glyph_column_o;
      seen.glyph_color   = glyph_color_o;
      seen.error_status  = error_status_o;
      tracker.check_glyph(seen);
    end
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_wide(1'b0);
    idle_max = 15;
    send_byte(8'h20, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(EscCode, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(EscCode, 1'b0);
    send_byte(EscCode, 1'b0);
    send_byte(8'hA1, 1'b0);
    send_byte(8'hA1, 1'b0);
    send_byte(8'hAF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hB0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC9, 1'b0);
    send_byte(8'hA1, 1'b0);
    send_byte(8'hCA, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hB5, 1'b0);
    send_byte(EscCode, 1'b0);
    send_byte(EscCode, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hD0, 1'b0);
    send_byte(8'hC0, 1'b1);
    send_byte(8'hA5, 1'b0);
    settle();

    run_phase(1'b0, 15, 40, 150);
    run_phase(1'b1, 0, 0, 120);
    run_phase(1'b0, 15, 0, 150);
    run_phase(1'b1, 15, 20, 180);
    run_phase(logic'($urandom_range(0, 1)), 15, 60, 150);

    if (tracker.failures == 0 && tracker.expected_glyphs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
